[rtl/core/hpc_pkg.sv]
// Shared widths, types and arithmetic helpers for the HSV pixel color pipeline.
// Holds the stage map, the divide-by-255 helpers and the gamma level function.
// No dependencies; every other file in rtl/core imports this package.
package hpc_pkg;

   // Field widths
   localparam int MAX_PIXELS = 1024;
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int HUE_W      = 12;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int CH_RED     = 0;
   localparam int CH_GREEN   = 1;
   localparam int CH_BLUE    = 2;
   localparam int CH_MAX     = (1 << CH_W) - 1;

   // Hue geometry
   localparam int HUE_PERIOD  = 360;
   localparam int SECTOR_DEG  = 60;
   localparam int NUM_SECTORS = HUE_PERIOD / SECTOR_DEG;
   localparam int HUE_WRAPS   = ((1 << HUE_W) - 1) / HUE_PERIOD;
   localparam int HM_W        = $clog2(HUE_PERIOD);
   localparam int SECT_W      = $clog2(NUM_SECTORS);
   localparam int REM_W       = $clog2(SECTOR_DEG);

   // Rounded rationals: p over 255, q and t over 255*60
   localparam int P_BIAS    = CH_MAX / 2;
   localparam int Q_DEN     = CH_MAX * SECTOR_DEG;
   localparam int Q_BIAS    = Q_DEN / 2;
   localparam int SR_W      = $clog2(Q_DEN + 1);
   localparam int PRD_W     = $clog2(CH_MAX * CH_MAX + P_BIAS + 1);
   localparam int NUM_W     = $clog2(CH_MAX * Q_DEN + Q_BIAS + 1);
   localparam int Q_SHIFT   = 32;
   localparam longint unsigned Q_RECIP = (64'd1 << Q_SHIFT) / Q_DEN;
   localparam int Q_RECIP_W = $clog2(Q_RECIP + 1);
   localparam int Q_PROD_W  = NUM_W + Q_RECIP_W;

   // Gamma 2.2 written as 11/5
   localparam int GAMMA_NUM_EXP = 11;
   localparam int GAMMA_DEN_EXP = 5;
   localparam int GAMMA_DEPTH   = 1 << CH_W;

   // Pipeline stage map
   localparam int ST_HUE     = 0;
   localparam int ST_SECTOR  = 1;
   localparam int ST_PROD    = 2;
   localparam int ST_NUM     = 3;
   localparam int ST_EST     = 4;
   localparam int ST_CHAN    = 5;
   localparam int ST_MUL     = 6;
   localparam int ST_DIV     = 7;
   localparam int ST_GAMMA   = 8;
   localparam int NUM_STAGES = 9;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CH_W;

   typedef logic [NUM_STAGES-1:0]         stage_vec_type;
   typedef logic [CH_W-1:0]               chan_type;
   typedef logic [NUM_CH-1:0][CH_W-1:0]   rgb_type;

   typedef enum logic {
      MODE_RGB,
      MODE_HSV
   } color_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLOR_MODE,
      CSR_BRIGHTNESS
   } csr_index_type;

   // First guess of x/255 as x*257/65536; low by at most one.
   function automatic chan_type div255_est(input logic [PRD_W-1:0] x);
      logic [PRD_W+CH_W-1:0] sum;
      sum = (PRD_W + CH_W)'(x) + ((PRD_W + CH_W)'(x) << CH_W);
      return sum[PRD_W +: CH_W];
   endfunction

   // Bump the guess when the remainder still holds a whole 255.
   function automatic chan_type div255_fix(input logic [PRD_W-1:0] x, input chan_type est);
      logic [PRD_W:0] rem;
      rem = (PRD_W + 1)'(x) - ((PRD_W + 1)'(est) << CH_W) + (PRD_W + 1)'(est);
      return (rem >= (PRD_W + 1)'(CH_MAX)) ? est + CH_W'(1) : est;
   endfunction

   // round(255*(x/255)^(11/5)): count of k with 32*x^11 >= (2k+1)^5*255^6,
   // found by binary search. Evaluated at elaboration only.
   function automatic chan_type gamma_value(input int unsigned level);
      logic [127:0] lhs;
      logic [127:0] rhs;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      lhs = 128'(1) << GAMMA_DEN_EXP;
      for (int n = 0; n < GAMMA_NUM_EXP; n++) begin
         lhs = lhs * 128'(level);
      end
      lo = 0;
      hi = GAMMA_DEPTH - 1;
      for (int step = 0; step < CH_W; step++) begin
         if (lo < hi) begin
            mid = (lo + hi) >> 1;
            rhs = 128'(1);
            for (int n = 0; n < GAMMA_DEN_EXP; n++) begin
               rhs = rhs * 128'(2 * mid + 1);
            end
            for (int n = 0; n < GAMMA_NUM_EXP - GAMMA_DEN_EXP; n++) begin
               rhs = rhs * 128'(CH_MAX);
            end
            if (rhs <= lhs) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
      end
      return CH_W'(lo);
   endfunction

endpackage

[rtl/core/hpc_pipe_ctrl.sv]
// Valid bits and per-stage advance enables of the color pipeline.
// Depends on hpc_pkg for the stage count.
module hpc_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output hpc_pkg::stage_vec_type stage_en
);
   import hpc_pkg::*;

   stage_vec_type valid_ff;
   stage_vec_type valid_in;

   // A stage advances when it is empty or its successor advances.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

[rtl/core/hpc_hsv_conv.sv]
// HSV to RGB front end: hue wrap, sector split, products, rounded quotients, source select.
// Occupies stages ST_HUE..ST_CHAN; depends on hpc_pkg.
module hpc_hsv_conv (
   input  logic                        clock,
   input  hpc_pkg::stage_vec_type      stage_en,
   input  hpc_pkg::color_mode_type     color_mode,
   input  logic [hpc_pkg::IDX_W-1:0]   req_pixel_index,
   input  logic [hpc_pkg::HUE_W-1:0]   req_hue,
   input  hpc_pkg::chan_type           req_saturation,
   input  hpc_pkg::chan_type           req_value,
   input  hpc_pkg::chan_type           req_red_in,
   input  hpc_pkg::chan_type           req_green_in,
   input  hpc_pkg::chan_type           req_blue_in,
   output logic [hpc_pkg::IDX_W-1:0]   conv_index,
   output hpc_pkg::rgb_type            conv_rgb
);
   import hpc_pkg::*;

   typedef enum logic [SECT_W-1:0] {
      SECT_RED,
      SECT_YELLOW,
      SECT_GREEN,
      SECT_CYAN,
      SECT_BLUE,
      SECT_MAGENTA
   } sector_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      rgb_type          rgb;
      chan_type         val;
   } carry_type;

   function automatic chan_type q_fix(input logic [NUM_W-1:0] x, input chan_type est);
      logic [NUM_W-1:0] rem;
      rem = x - NUM_W'(Q_DEN) * NUM_W'(est);
      return (rem >= NUM_W'(Q_DEN)) ? est + CH_W'(1) : est;
   endfunction

   // Stage 0: hue mod 360
   carry_type         s0_carry_ff;
   chan_type          s0_sat_ff;
   logic [HM_W-1:0]   s0_hm_ff;
   logic [HM_W-1:0]   s0_hm_in;
   carry_type         s0_carry_in;

   always_comb begin
      s0_hm_in = HM_W'(req_hue);
      for (int j = 1; j <= HUE_WRAPS; j++) begin
         if (req_hue >= HUE_W'(j * HUE_PERIOD)) begin
            s0_hm_in = HM_W'(req_hue - HUE_W'(j * HUE_PERIOD));
         end
      end
      s0_carry_in.index         = req_pixel_index;
      s0_carry_in.rgb[CH_RED]   = req_red_in;
      s0_carry_in.rgb[CH_GREEN] = req_green_in;
      s0_carry_in.rgb[CH_BLUE]  = req_blue_in;
      s0_carry_in.val           = req_value;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_HUE]) begin
         s0_carry_ff <= s0_carry_in;
         s0_sat_ff   <= req_saturation;
         s0_hm_ff    <= s0_hm_in;
      end
   end

   // Stage 1: sector and degrees into the sector
   carry_type          s1_carry_ff;
   chan_type           s1_sat_ff;
   sector_type         s1_sector_ff;
   sector_type         s1_sector_in;
   logic [REM_W-1:0]   s1_rem_ff;
   logic [REM_W-1:0]   s1_rem_in;

   always_comb begin
      s1_sector_in = SECT_RED;
      s1_rem_in    = REM_W'(s0_hm_ff);
      for (int j = 1; j < NUM_SECTORS; j++) begin
         if (s0_hm_ff >= HM_W'(j * SECTOR_DEG)) begin
            s1_sector_in = sector_type'(SECT_W'(j));
            s1_rem_in    = REM_W'(s0_hm_ff - HM_W'(j * SECTOR_DEG));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SECTOR]) begin
         s1_carry_ff  <= s0_carry_ff;
         s1_sat_ff    <= s0_sat_ff;
         s1_sector_ff <= s1_sector_in;
         s1_rem_ff    <= s1_rem_in;
      end
   end

   // Stage 2: s*rem, s*(60-rem), 255-s
   carry_type          s2_carry_ff;
   sector_type         s2_sector_ff;
   logic [SR_W-1:0]    s2_sr_q_ff;
   logic [SR_W-1:0]    s2_sr_t_ff;
   chan_type           s2_sat_inv_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD]) begin
         s2_carry_ff   <= s1_carry_ff;
         s2_sector_ff  <= s1_sector_ff;
         s2_sr_q_ff    <= SR_W'(s1_sat_ff) * SR_W'(s1_rem_ff);
         s2_sr_t_ff    <= SR_W'(s1_sat_ff) * (SR_W'(SECTOR_DEG) - SR_W'(s1_rem_ff));
         s2_sat_inv_ff <= CH_W'(CH_MAX) - s1_sat_ff;
      end
   end

   // Stage 3: numerators v*(15300 - s*r), v*(255 - s)
   carry_type          s3_carry_ff;
   sector_type         s3_sector_ff;
   logic [NUM_W-1:0]   s3_num_q_ff;
   logic [NUM_W-1:0]   s3_num_t_ff;
   logic [PRD_W-1:0]   s3_num_p_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_NUM]) begin
         s3_carry_ff  <= s2_carry_ff;
         s3_sector_ff <= s2_sector_ff;
         s3_num_q_ff  <= NUM_W'(s2_carry_ff.val)
                         * (NUM_W'(Q_DEN) - NUM_W'(s2_sr_q_ff));
         s3_num_t_ff  <= NUM_W'(s2_carry_ff.val)
                         * (NUM_W'(Q_DEN) - NUM_W'(s2_sr_t_ff));
         s3_num_p_ff  <= PRD_W'(s2_carry_ff.val) * PRD_W'(s2_sat_inv_ff);
      end
   end

   // Stage 4: add the half-divisor and take reciprocal estimates
   carry_type          s4_carry_ff;
   sector_type         s4_sector_ff;
   logic [NUM_W-1:0]   s4_x_q_ff;
   logic [NUM_W-1:0]   s4_x_t_ff;
   logic [PRD_W-1:0]   s4_x_p_ff;
   chan_type           s4_est_q_ff;
   chan_type           s4_est_t_ff;
   chan_type           s4_est_p_ff;
   logic [NUM_W-1:0]   s4_x_q_in;
   logic [NUM_W-1:0]   s4_x_t_in;
   logic [PRD_W-1:0]   s4_x_p_in;
   logic [Q_PROD_W-1:0] prod_q;
   logic [Q_PROD_W-1:0] prod_t;

   always_comb begin
      s4_x_q_in = s3_num_q_ff + NUM_W'(Q_BIAS);
      s4_x_t_in = s3_num_t_ff + NUM_W'(Q_BIAS);
      s4_x_p_in = s3_num_p_ff + PRD_W'(P_BIAS);
      prod_q    = Q_PROD_W'(s4_x_q_in) * Q_PROD_W'(Q_RECIP);
      prod_t    = Q_PROD_W'(s4_x_t_in) * Q_PROD_W'(Q_RECIP);
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_EST]) begin
         s4_carry_ff  <= s3_carry_ff;
         s4_sector_ff <= s3_sector_ff;
         s4_x_q_ff    <= s4_x_q_in;
         s4_x_t_ff    <= s4_x_t_in;
         s4_x_p_ff    <= s4_x_p_in;
         s4_est_q_ff  <= prod_q[Q_SHIFT +: CH_W];
         s4_est_t_ff  <= prod_t[Q_SHIFT +: CH_W];
         s4_est_p_ff  <= div255_est(s4_x_p_in);
      end
   end

   // Stage 5: correct quotients, arrange by sector, pick the color source
   logic [IDX_W-1:0] s5_index_ff;
   rgb_type          s5_rgb_ff;
   rgb_type          s5_rgb_in;
   chan_type         p_val;
   chan_type         q_val;
   chan_type         t_val;
   chan_type         v_val;

   always_comb begin
      p_val = div255_fix(s4_x_p_ff, s4_est_p_ff);
      q_val = q_fix(s4_x_q_ff, s4_est_q_ff);
      t_val = q_fix(s4_x_t_ff, s4_est_t_ff);
      v_val = s4_carry_ff.val;
      s5_rgb_in = s4_carry_ff.rgb;
      if (color_mode == MODE_HSV) begin
         case (s4_sector_ff)
            SECT_YELLOW: begin
               s5_rgb_in[CH_RED] = q_val; s5_rgb_in[CH_GREEN] = v_val; s5_rgb_in[CH_BLUE] = p_val;
            end
            SECT_GREEN: begin
               s5_rgb_in[CH_RED] = p_val; s5_rgb_in[CH_GREEN] = v_val; s5_rgb_in[CH_BLUE] = t_val;
            end
            SECT_CYAN: begin
               s5_rgb_in[CH_RED] = p_val; s5_rgb_in[CH_GREEN] = q_val; s5_rgb_in[CH_BLUE] = v_val;
            end
            SECT_BLUE: begin
               s5_rgb_in[CH_RED] = t_val; s5_rgb_in[CH_GREEN] = p_val; s5_rgb_in[CH_BLUE] = v_val;
            end
            SECT_MAGENTA: begin
               s5_rgb_in[CH_RED] = v_val; s5_rgb_in[CH_GREEN] = p_val; s5_rgb_in[CH_BLUE] = q_val;
            end
            default: begin
               s5_rgb_in[CH_RED] = v_val; s5_rgb_in[CH_GREEN] = t_val; s5_rgb_in[CH_BLUE] = p_val;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_CHAN]) begin
         s5_index_ff <= s4_carry_ff.index;
         s5_rgb_ff   <= s5_rgb_in;
      end
   end

   assign conv_index = s5_index_ff;
   assign conv_rgb   = s5_rgb_ff;

endmodule

[rtl/core/hpc_scale_gamma.sv]
// Brightness scaling floor(c*b/255) and gamma 2.2 lookup on three channels.
// Occupies stages ST_MUL..ST_GAMMA; depends on hpc_pkg.
module hpc_scale_gamma (
   input  logic                        clock,
   input  hpc_pkg::stage_vec_type      stage_en,
   input  hpc_pkg::chan_type           brightness,
   input  logic [hpc_pkg::IDX_W-1:0]   conv_index,
   input  hpc_pkg::rgb_type            conv_rgb,
   output logic [hpc_pkg::IDX_W-1:0]   rsp_pixel_out_index,
   output hpc_pkg::chan_type           rsp_red_out,
   output hpc_pkg::chan_type           rsp_green_out,
   output hpc_pkg::chan_type           rsp_blue_out
);
   import hpc_pkg::*;

   chan_type gamma_lut [GAMMA_DEPTH];

   for (genvar g = 0; g < GAMMA_DEPTH; g++) begin : g_gamma
      localparam chan_type LEVEL = gamma_value(g);
      assign gamma_lut[g] = LEVEL;
   end

   logic [IDX_W-1:0]                 s6_index_ff;
   logic [NUM_CH-1:0][PRD_W-1:0]     s6_prod_ff;
   logic [IDX_W-1:0]                 s7_index_ff;
   rgb_type                          s7_scaled_ff;
   logic [IDX_W-1:0]                 s8_index_ff;
   rgb_type                          s8_level_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_MUL]) begin
         s6_index_ff <= conv_index;
         for (int c = 0; c < NUM_CH; c++) begin
            s6_prod_ff[c] <= PRD_W'(conv_rgb[c]) * PRD_W'(brightness);
         end
      end
      if (stage_en[ST_DIV]) begin
         s7_index_ff <= s6_index_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            s7_scaled_ff[c] <= div255_fix(s6_prod_ff[c], div255_est(s6_prod_ff[c]));
         end
      end
      if (stage_en[ST_GAMMA]) begin
         s8_index_ff <= s7_index_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            s8_level_ff[c] <= gamma_lut[s7_scaled_ff[c]];
         end
      end
   end

   assign rsp_pixel_out_index = s8_index_ff;
   assign rsp_red_out         = s8_level_ff[CH_RED];
   assign rsp_green_out       = s8_level_ff[CH_GREEN];
   assign rsp_blue_out        = s8_level_ff[CH_BLUE];

endmodule

[rtl/core/hsv_pixel_color_pipeline.sv]
// Top level of the HSV pixel color pipeline: CSRs, pipeline control, datapath.
// Depends on hpc_pkg, hpc_pipe_ctrl, hpc_hsv_conv and hpc_scale_gamma.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_ready  pixel_index, hue, saturation, value, rgb in
//   rsp_*     out        rsp_valid/rsp_ready  pixel_out_index, red/green/blue out
//   csr_*     in         csr_wr_en            csr_index, csr_wdata (no read-back)
//
// Nine register stages; a request taken into stage 0 shows on rsp_valid once it reaches
// stage 8 and leaves there when rsp_ready is high.
// One request per cycle when the output is drained: each stage holds a valid bit
// and advances when it is empty or the stage after it advances, so bubbles close
// up and req_ready stays high while a finished result waits as long as any stage
// is free. Reset is synchronous and clears the valid bits and the CSRs only.
// Change the CSRs only while no request is in flight.
module hsv_pixel_color_pipeline (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hpc_pkg::IDX_W-1:0]        req_pixel_index,
   input  logic [hpc_pkg::HUE_W-1:0]        req_hue,
   input  hpc_pkg::chan_type                req_saturation,
   input  hpc_pkg::chan_type                req_value,
   input  hpc_pkg::chan_type                req_red_in,
   input  hpc_pkg::chan_type                req_green_in,
   input  hpc_pkg::chan_type                req_blue_in,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hpc_pkg::IDX_W-1:0]        rsp_pixel_out_index,
   output hpc_pkg::chan_type                rsp_red_out,
   output hpc_pkg::chan_type                rsp_green_out,
   output hpc_pkg::chan_type                rsp_blue_out,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [hpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hpc_pkg::*;

   color_mode_type    color_mode_ff;
   chan_type          brightness_ff;
   stage_vec_type     stage_en;
   logic [IDX_W-1:0]  conv_index;
   rgb_type           conv_rgb;

   // CSRs: color source select and global brightness
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_RGB;
         brightness_ff <= CH_W'(CH_MAX);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COLOR_MODE: color_mode_ff <= color_mode_type'(csr_wdata[0]);
            CSR_BRIGHTNESS: brightness_ff <= csr_wdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   // Valid bits and advance enables for all nine stages
   hpc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .stage_en  (stage_en)
   );

   // Stages 0-5: hue wrap, sector split, rounded p/q/t, source select
   hpc_hsv_conv u_conv (
      .clock           (clock),
      .stage_en        (stage_en),
      .color_mode      (color_mode_ff),
      .req_pixel_index (req_pixel_index),
      .req_hue         (req_hue),
      .req_saturation  (req_saturation),
      .req_value       (req_value),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .conv_index      (conv_index),
      .conv_rgb        (conv_rgb)
   );

   // Stages 6-8: brightness multiply, divide by 255, gamma table
   hpc_scale_gamma u_scale (
      .clock               (clock),
      .stage_en            (stage_en),
      .brightness          (brightness_ff),
      .conv_index          (conv_index),
      .conv_rgb            (conv_rgb),
      .rsp_pixel_out_index (rsp_pixel_out_index),
      .rsp_red_out         (rsp_red_out),
      .rsp_green_out       (rsp_green_out),
      .rsp_blue_out        (rsp_blue_out)
   );

   // A free output slot always opens the whole pipe to a new request.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while the output stage can move");

   // Back-pressure only comes from a stalled, full output.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a held result");

   // Reset empties the pipe.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[bench/tb_hsv_pixel_color_pipeline.sv]
`timescale 1ns / 100ps
// Self-checking bench for hsv_pixel_color_pipeline: a directed table, then random phases.
// Predicts pixels with its own HSV, brightness and gamma arithmetic; needs hpc_pkg and the RTL.
module tb_hsv_pixel_color_pipeline;
   import hpc_pkg::*;

   localparam int CYCLE_LIMIT    = 300000;
   localparam int SETTLE_CYCLES  = NUM_STAGES + 4;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_REQUESTS = 108;
   localparam int MAX_WAIT       = 6;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic [HUE_W-1:0] hue;
      chan_type         sat;
      chan_type         val;
      chan_type         red;
      chan_type         green;
      chan_type         blue;
   } pixel_request_type;

   typedef struct {
      logic [IDX_W-1:0] index;
      chan_type         red;
      chan_type         green;
      chan_type         blue;
   } pixel_drive_type;

   // One directed row: settings it runs under, the request, and, where known_drive is set,
   // the drive levels typed in by hand instead of taken from the predictor.
   typedef struct {
      color_mode_type mode;
      int unsigned    bright;
      bit             known_drive;
      int unsigned    index;
      int unsigned    hue;
      int unsigned    sat;
      int unsigned    val;
      int unsigned    red;
      int unsigned    green;
      int unsigned    blue;
      int unsigned    want_red;
      int unsigned    want_green;
      int unsigned    want_blue;
   } color_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [IDX_W-1:0]      req_pixel_index;
   logic [HUE_W-1:0]      req_hue;
   chan_type              req_saturation;
   chan_type              req_value;
   chan_type              req_red_in;
   chan_type              req_green_in;
   chan_type              req_blue_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IDX_W-1:0]      rsp_pixel_out_index;
   chan_type              rsp_red_out;
   chan_type              rsp_green_out;
   chan_type              rsp_blue_out;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor copy of the registers and the gamma curve
   color_mode_type mode_setting;
   int unsigned    bright_setting;
   chan_type       gamma_curve [GAMMA_DEPTH];

   pixel_drive_type pending_drives [$];
   color_row_type   color_table [$];
   int unsigned     error_count;
   int unsigned     cycle_count;
   bit              idle_on;

   always #5 clock = ~clock;

   hsv_pixel_color_pipeline dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_index     (req_pixel_index),
      .req_hue             (req_hue),
      .req_saturation      (req_saturation),
      .req_value           (req_value),
      .req_red_in          (req_red_in),
      .req_green_in        (req_green_in),
      .req_blue_in         (req_blue_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_out_index (rsp_pixel_out_index),
      .rsp_red_out         (rsp_red_out),
      .rsp_green_out       (rsp_green_out),
      .rsp_blue_out        (rsp_blue_out),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Gamma 2.2 as 11/5: the level is the number of k in 0..254 with
   // 32*x^11 >= (2k+1)^5 * 255^6, scanned upward (the curve is monotone in k).
   function automatic chan_type gamma_level(int unsigned x);
      logic [127:0] lhs;
      logic [127:0] rhs;
      int unsigned  level;
      lhs = 128'd32;
      for (int n = 0; n < 11; n++) lhs = lhs * 128'(x);
      level = 0;
      for (int k = 0; k < CH_MAX; k++) begin
         rhs = 128'd1;
         for (int n = 0; n < 5; n++) rhs = rhs * 128'(2 * k + 1);
         for (int n = 0; n < 6; n++) rhs = rhs * 128'(CH_MAX);
         if (lhs < rhs) break;
         level++;
      end
      return chan_type'(level);
   endfunction

   // Full color path: pick the source color, scale by brightness (floor), look up gamma.
   function automatic pixel_drive_type predict_drive(pixel_request_type r);
      pixel_drive_type d;
      int unsigned  deg;
      int unsigned  sector;
      int unsigned  offset;
      int unsigned  s;
      int unsigned  v;
      int unsigned  p;
      int unsigned  q;
      int unsigned  t;
      int unsigned  rgb [3];
      if (mode_setting == MODE_HSV) begin
         deg    = r.hue % 360;
         sector = deg / 60;
         offset = deg % 60;
         s      = r.sat;
         v      = r.val;
         // Round to nearest, an exact half goes up: (2n + d) / 2d
         p = (2 * v * (255 - s) + 255) / 510;
         q = (2 * v * (15300 - s * offset) + 15300) / 30600;
         t = (2 * v * (15300 - s * (60 - offset)) + 15300) / 30600;
         case (sector)
            1: rgb = '{q, v, p};
            2: rgb = '{p, v, t};
            3: rgb = '{p, q, v};
            4: rgb = '{t, p, v};
            5: rgb = '{v, p, q};
            default: rgb = '{v, t, p};
         endcase
      end else begin
         rgb = '{r.red, r.green, r.blue};
      end
      d.index = r.index;
      d.red   = gamma_curve[(rgb[0] * bright_setting) / 255];
      d.green = gamma_curve[(rgb[1] * bright_setting) / 255];
      d.blue  = gamma_curve[(rgb[2] * bright_setting) / 255];
      return d;
   endfunction

   // Random request; hue leans toward sector edges and the midpoint tie,
   // saturation and value toward their extremes.
   function automatic pixel_request_type random_pixel();
      pixel_request_type r;
      int unsigned    pick;
      r.index = IDX_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         pick  = $urandom_range(0, 3);
         r.hue = HUE_W'(SECTOR_DEG * $urandom_range(0, 67)
                        + (pick == 0 ? 0 : pick == 1 ? 1 : pick == 2 ? 30 : 59));
      end else begin
         r.hue = HUE_W'($urandom);
      end
      pick  = $urandom_range(0, 7);
      r.sat = (pick == 0) ? chan_type'(0) : (pick == 1) ? chan_type'(CH_MAX)
                                          : chan_type'($urandom);
      pick  = $urandom_range(0, 7);
      r.val = (pick == 0) ? chan_type'(0) : (pick == 1) ? chan_type'(CH_MAX)
                                          : chan_type'($urandom);
      r.red   = chan_type'($urandom);
      r.green = chan_type'($urandom);
      r.blue  = chan_type'($urandom);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Offer one request after a random gap, hold it until taken, then queue its drive levels.
   task automatic send_pixel(pixel_request_type r, pixel_drive_type want);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_index <= r.index;
      req_hue         <= r.hue;
      req_saturation  <= r.sat;
      req_value       <= r.val;
      req_red_in      <= r.red;
      req_green_in    <= r.green;
      req_blue_in     <= r.blue;
      do @(posedge clock); while (!req_ready);
      pending_drives.push_back(want);
   endtask

   // Drop valid and wait for every outstanding pixel; sample on the falling edge so
   // the check process has already retired the last one.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Write both registers back to back, and mirror them into the predictor.
   task automatic apply_settings(color_mode_type mode, int unsigned bright);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COLOR_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_index <= CSR_BRIGHTNESS;
      csr_wdata <= CSR_DATA_W'(bright);
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      mode_setting   = mode;
      bright_setting = bright;
   endtask

   // Result side: stall a random number of cycles, then hold ready until a pixel is taken.
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each taken pixel against the oldest queued prediction, field by field.
   always @(posedge clock) begin : check_pixels
      pixel_drive_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            report_mismatch($sformatf("pixel %0d arrived with nothing outstanding",
                                      rsp_pixel_out_index));
         end else begin
            want = pending_drives.pop_front();
            if (rsp_pixel_out_index !== want.index)
               report_mismatch($sformatf("index got %0d want %0d",
                                         rsp_pixel_out_index, want.index));
            if (rsp_red_out !== want.red)
               report_mismatch($sformatf("pixel %0d red got %0d want %0d",
                                         want.index, rsp_red_out, want.red));
            if (rsp_green_out !== want.green)
               report_mismatch($sformatf("pixel %0d green got %0d want %0d",
                                         want.index, rsp_green_out, want.green));
            if (rsp_blue_out !== want.blue)
               report_mismatch($sformatf("pixel %0d blue got %0d want %0d",
                                         want.index, rsp_blue_out, want.blue));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      pixel_request_type req;
      pixel_drive_type   want;
      color_mode_type    phase_mode;
      int unsigned       phase_bright;

      // Hold every input at a known value from time zero
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_index = '0;
      req_hue         = '0;
      req_saturation  = '0;
      req_value       = '0;
      req_red_in      = '0;
      req_green_in    = '0;
      req_blue_in     = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_COLOR_MODE;
      csr_wdata       = '0;
      error_count     = 0;
      cycle_count     = 0;
      idle_on         = 1'b1;
      mode_setting    = MODE_RGB;
      bright_setting  = CH_MAX;
      for (int x = 0; x < GAMMA_DEPTH; x++) gamma_curve[x] = gamma_level(x);

      // Directed rows. The first ones run on the reset settings without any write.
      //                  mode      bright kn  index hue  sat  val  red  grn  blu  r    g    b
      color_table = '{
         '{MODE_RGB, 255, 1'b1, 0,    0,    0,   0,   0,   0,   0,   0,   0,   0  },
         '{MODE_RGB, 255, 1'b1, 1023, 0,    0,   0,   255, 255, 255, 255, 255, 255},
         '{MODE_RGB, 255, 1'b0, 512,  4095, 255, 255, 255, 0,   128, 0,   0,   0  },
         '{MODE_RGB, 255, 1'b0, 1,    0,    0,   0,   1,   2,   254, 0,   0,   0  },
         // HSV fields are ignored in RGB mode
         '{MODE_RGB, 255, 1'b1, 300,  4095, 255, 255, 0,   255, 0,   0,   255, 0  },
         '{MODE_RGB, 0,   1'b1, 682,  0,    0,   0,   255, 255, 255, 0,   0,   0  },
         '{MODE_RGB, 1,   1'b0, 341,  0,    0,   0,   255, 255, 255, 0,   0,   0  },
         // Primary and secondary hues at full saturation sit on exact sector edges
         '{MODE_HSV, 255, 1'b1, 10,   0,    255, 255, 0,   0,   0,   255, 0,   0  },
         '{MODE_HSV, 255, 1'b1, 11,   60,   255, 255, 0,   0,   0,   255, 255, 0  },
         '{MODE_HSV, 255, 1'b1, 12,   120,  255, 255, 0,   0,   0,   0,   255, 0  },
         '{MODE_HSV, 255, 1'b1, 13,   180,  255, 255, 0,   0,   0,   0,   255, 255},
         '{MODE_HSV, 255, 1'b1, 14,   240,  255, 255, 0,   0,   0,   0,   0,   255},
         '{MODE_HSV, 255, 1'b1, 15,   300,  255, 255, 0,   0,   0,   255, 0,   255},
         // Hue wraps at 360; largest hue the field carries
         '{MODE_HSV, 255, 1'b1, 16,   360,  255, 255, 0,   0,   0,   255, 0,   0  },
         '{MODE_HSV, 255, 1'b0, 17,   4095, 255, 255, 0,   0,   0,   0,   0,   0  },
         '{MODE_HSV, 255, 1'b0, 18,   59,   255, 255, 0,   0,   0,   0,   0,   0  },
         // Grey and black; RGB fields are ignored in HSV mode
         '{MODE_HSV, 255, 1'b1, 19,   77,   0,   255, 0,   0,   0,   255, 255, 255},
         '{MODE_HSV, 255, 1'b1, 20,   200,  255, 0,   255, 255, 255, 0,   0,   0  },
         '{MODE_HSV, 255, 1'b0, 21,   359,  128, 200, 255, 255, 255, 0,   0,   0  },
         // Mid-sector at full saturation: t or q lands exactly on a half and rounds up; then reduced brightness rows
         '{MODE_HSV, 255, 1'b0, 22,   30,   255, 255, 0,   0,   0,   0,   0,   0  },
         '{MODE_HSV, 255, 1'b0, 23,   90,   255, 255, 0,   0,   0,   0,   0,   0  },
         '{MODE_HSV, 128, 1'b0, 1000, 0,    255, 255, 0,   0,   0,   0,   0,   0  },
         '{MODE_HSV, 0,   1'b1, 1001, 45,   200, 255, 0,   0,   0,   0,   0,   0  }
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (color_table[i]) begin
         if (color_table[i].mode != mode_setting || color_table[i].bright != bright_setting) begin
            settle_pipeline();
            apply_settings(color_table[i].mode, color_table[i].bright);
         end
         req.index = IDX_W'(color_table[i].index);
         req.hue   = HUE_W'(color_table[i].hue);
         req.sat   = chan_type'(color_table[i].sat);
         req.val   = chan_type'(color_table[i].val);
         req.red   = chan_type'(color_table[i].red);
         req.green = chan_type'(color_table[i].green);
         req.blue  = chan_type'(color_table[i].blue);
         if (color_table[i].known_drive) begin
            want.index = req.index;
            want.red   = chan_type'(color_table[i].want_red);
            want.green = chan_type'(color_table[i].want_green);
            want.blue  = chan_type'(color_table[i].want_blue);
         end else begin
            want = predict_drive(req);
         end
         send_pixel(req, want);
      end

      // Random phases: fresh settings each time, the brightness extremes first;
      // every fourth phase runs with no gaps or stalls on either side.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         phase_mode   = (phase % 2 == 0) ? MODE_HSV : MODE_RGB;
         phase_bright = (phase < 2) ? CH_MAX : (phase < 4) ? 0 : (phase < 6) ? 1
                                             : $urandom_range(0, CH_MAX);
         apply_settings(phase_mode, phase_bright);
         idle_on = (phase % 4 != 3);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            req = random_pixel();
            send_pixel(req, predict_drive(req));
         end
      end

      // Let the last pixels drain, then keep the clock running so stragglers still get checked
      idle_on = 1'b1;
      settle_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
